### rtl/core/exptok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exptok_pkg: shared types and constants for the expression tokenizer
// Character codes, token kinds, scan modes and the result record that the
// tokenizer queues and the port checker decodes.
// ----------------------------------------------------------------------------
package exptok_pkg;

  // Default width of the character offset and run length counters
  localparam int OFFSET_WIDTH_DEF = 16;

  // Result queue depth (one item may queue two tokens)
  localparam int QUEUE_DEPTH = 4;

  // Field widths on the result side
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 31;
  localparam int POS_W    = 16;
  localparam int TDATA_W  = 72;

  // Largest number value (saturation point)
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;

  // Token kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUNCT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  // Scan modes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  // One result token
  typedef struct packed {
    logic               last;
    logic [POS_W-1:0]   length;
    logic [POS_W-1:0]   start;
    logic [VALUE_W-1:0] value;
    logic [CHAR_W-1:0]  ch;
    kind_t              kind;
  } token_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_SEMI) || (c == CH_EQ);
  endfunction

endpackage

### rtl/core/expression_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer: character stream to token stream
// Skips whitespace, emits punctuation, identifier, number, end and error
// tokens, each with its start offset and length.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[7:0] char_in
//  m_axis   | out | tuser kind, tdata char/value/start/length, tlast last
//
// One character is classified and the scan state updated in the cycle its
// transfer completes; its tokens (none, one or two) enter a four-entry result
// queue in that cycle and appear on m_axis from the next cycle on.
// s_axis_tready is high while the queue has room for two tokens, so one
// character per cycle is taken as long as m_axis drains about one token a
// cycle; a stalled m_axis fills the queue and then holds s_axis off.
// Synchronous reset returns the scan to idle at offset 0 and empties the queue.
//
module expression_tokenizer #(
  parameter int OFFSET_WIDTH = exptok_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] token_char, [38:8] number_value, [54:39] start_offset,
  // [70:55] token_length, [71] zero
  output logic [exptok_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [exptok_pkg::KIND_W-1:0]  m_axis_tuser,   // [2:0] token_kind
  output logic                          m_axis_tlast    // last_token
);
  import exptok_pkg::*;

  localparam int OW    = OFFSET_WIDTH;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] RUN_MAX = {OW{1'b1}};
  localparam logic [OW-1:0] ONE_OW  = {{(OW-1){1'b0}}, 1'b1};

  // Scan state
  mode_t              mode, mode_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [OW-1:0]      run_start, run_start_next;
  logic [OW-1:0]      run_length, run_length_next;
  logic [7:0]         first_letter, first_letter_next;
  logic [OW-1:0]      char_offset, char_offset_next;

  // Result queue
  token_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  logic               in_xfer, out_xfer;
  logic [7:0]         c;
  logic               letter, digit, space, punct, nul;
  logic [VALUE_W+3:0] acc_x10;
  logic [VALUE_W-1:0] acc_sat;
  logic [OW-1:0]      run_grown;
  logic               flush;
  token_t             tok_run, tok_char, res0, res1;
  logic               run_valid, char_valid;
  logic [1:0]         n_res;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count <= CNT_W'(QUEUE_DEPTH - 2));

  // Character classes
  assign c      = s_axis_tdata;
  assign letter = (c >= CH_LOWA) && (c <= CH_LOWZ);
  assign digit  = (c >= CH_DIG0) && (c <= CH_DIG9);
  assign space  = is_space(c);
  assign punct  = is_punct(c);
  assign nul    = (c == CH_NUL);

  // Decimal accumulate: acc*10 + digit as shift-add, saturating
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_W{1'b0}}, c[3:0]};
  assign acc_sat = (acc_x10[VALUE_W+3:VALUE_W] != 4'd0) ? VALUE_MAX : acc_x10[VALUE_W-1:0];
  assign run_grown = (run_length == RUN_MAX) ? run_length : run_length + ONE_OW;

  // A pending run (or idle) is closed by anything that does not extend it
  assign flush = (mode != MODE_DISCARD) && !((mode == MODE_IDENT) && letter) &&
                 !((mode == MODE_NUMBER) && digit);

  // Next scan state
  always_comb begin
    mode_next         = mode;
    acc_next          = acc;
    run_start_next    = run_start;
    run_length_next   = run_length;
    first_letter_next = first_letter;
    char_offset_next  = char_offset + ONE_OW;
    if (mode == MODE_DISCARD) begin
      if (nul) begin
        mode_next         = MODE_IDLE;
        acc_next          = '0;
        run_start_next    = '0;
        run_length_next   = '0;
        first_letter_next = '0;
        char_offset_next  = '0;
      end
    end else if ((mode == MODE_IDENT) && letter) begin
      run_length_next = run_grown;
    end else if ((mode == MODE_NUMBER) && digit) begin
      acc_next        = acc_sat;
      run_length_next = run_grown;
    end else begin
      mode_next = MODE_IDLE;
      if (nul) begin
        acc_next          = '0;
        run_start_next    = '0;
        run_length_next   = '0;
        first_letter_next = '0;
        char_offset_next  = '0;
      end else if (space || punct) begin
        mode_next = MODE_IDLE;
      end else if (letter) begin
        mode_next         = MODE_IDENT;
        first_letter_next = c;
        run_start_next    = char_offset;
        run_length_next   = ONE_OW;
        acc_next          = '0;
      end else if (digit) begin
        mode_next         = MODE_NUMBER;
        first_letter_next = '0;
        run_start_next    = char_offset;
        run_length_next   = ONE_OW;
        acc_next          = {{(VALUE_W-4){1'b0}}, c[3:0]};
      end else begin
        mode_next = MODE_DISCARD;
      end
    end
  end

  // Tokens for this character
  always_comb begin
    tok_run        = '0;
    tok_run.start  = POS_W'(run_start);
    tok_run.length = POS_W'(run_length);
    run_valid      = 1'b0;
    case (mode)
      MODE_IDENT: begin
        tok_run.kind = KIND_IDENT;
        tok_run.ch   = first_letter;
        run_valid    = flush;
      end
      MODE_NUMBER: begin
        tok_run.kind  = KIND_NUMBER;
        tok_run.value = acc;
        run_valid     = flush;
      end
      default: begin
        run_valid = 1'b0;
      end
    endcase

    tok_char        = '0;
    tok_char.start  = POS_W'(char_offset);
    tok_char.length = POS_W'(1);
    tok_char.ch     = c;
    char_valid      = 1'b0;
    if (flush) begin
      if (nul) begin
        tok_char.kind   = KIND_END;
        tok_char.ch     = '0;
        tok_char.length = '0;
        tok_char.last   = 1'b1;
        char_valid      = 1'b1;
      end else if (punct) begin
        tok_char.kind = KIND_PUNCT;
        char_valid    = 1'b1;
      end else if (!space && !letter && !digit) begin
        tok_char.kind = KIND_ERROR;
        tok_char.last = 1'b1;
        char_valid    = 1'b1;
      end
    end

    // Flushed run goes first
    if (run_valid) begin
      res0  = tok_run;
      res1  = tok_char;
      n_res = char_valid ? 2'd2 : 2'd1;
    end else begin
      res0  = tok_char;
      res1  = tok_char;
      n_res = char_valid ? 2'd1 : 2'd0;
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      acc          <= '0;
      run_start    <= '0;
      run_length   <= '0;
      first_letter <= '0;
      char_offset  <= '0;
    end else if (in_xfer) begin
      mode         <= mode_next;
      acc          <= acc_next;
      run_start    <= run_start_next;
      run_length   <= run_length_next;
      first_letter <= first_letter_next;
      char_offset  <= char_offset_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (in_xfer && (n_res == 2'd2)) begin
      queue[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (in_xfer ? CNT_W'(n_res) : CNT_W'(0)) -
               (out_xfer ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // Result port
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = queue[rd_ptr].kind;
  assign m_axis_tlast  = queue[rd_ptr].last;
  assign m_axis_tdata  = {1'b0, queue[rd_ptr].length, queue[rd_ptr].start,
                          queue[rd_ptr].value, queue[rd_ptr].ch};

endmodule

### rtl/core/exptok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exptok_checker: port checks for the expression tokenizer
// Watches the result stream and checks token records for consistency.
// ----------------------------------------------------------------------------
module exptok_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [exptok_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [exptok_pkg::KIND_W-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);
  import exptok_pkg::*;

  logic is_end, is_err, is_single;

  assign is_end    = (m_axis_tuser == KIND_END);
  assign is_err    = (m_axis_tuser == KIND_ERROR);
  assign is_single = (m_axis_tuser == KIND_PUNCT) || is_err;

  // A stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result token changed while stalled");

  // Only end and error tokens close a string
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (is_end || is_err)))
    else $error("tlast does not match token kind");

  // End token has zero length, value and character
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_end |-> (m_axis_tdata[70:55] == 16'd0) &&
      (m_axis_tdata[38:0] == 39'd0))
    else $error("end token carries data");

  // Punctuation and error tokens are one character long
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_single |-> (m_axis_tdata[70:55] == 16'd1) &&
      (m_axis_tdata[38:8] == 31'd0))
    else $error("single-character token malformed");

  // Identifier tokens carry a lower-case first letter and no value
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_IDENT) |->
      (m_axis_tdata[38:8] == 31'd0) && (m_axis_tdata[7:0] >= CH_LOWA) &&
      (m_axis_tdata[7:0] <= CH_LOWZ))
    else $error("identifier token malformed");

endmodule

bind expression_tokenizer exptok_checker u_exptok_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for expression_tokenizer
// Streams character strings into the tokenizer and checks every token that
// leaves it against a cycle-free scan model kept in a scoreboard. Covers a
// short directed string set, about a thousand characters of random
// expressions with noise, a receiver hold-off that backs the block up, and a
// closing string whose number saturates.
// ----------------------------------------------------------------------------
module testbench;
  import exptok_pkg::*;

  localparam int          RANDOM_ITEMS = 960;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT        = 600000;
  localparam int          ERR_SHOWN    = 50;

  localparam logic [7:0] PUNCT_SET [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                           CH_LPAR, CH_RPAR, CH_SEMI, CH_EQ};

  // Scan model and queue of tokens still to come out of the block
  class token_scoreboard;
    token_t             token_q[$];
    int                 errors;
    int                 chars_taken;
    int                 strings;
    int                 kind_seen[5];
    mode_t              mode;
    logic [VALUE_W-1:0] acc;
    logic [POS_W-1:0]   run_start;
    logic [POS_W-1:0]   run_len;
    logic [POS_W-1:0]   offset;
    logic [7:0]         first_ch;

    function new();
      restart();
    endfunction

    function void restart();
      mode      = MODE_IDLE;
      acc       = '0;
      run_start = '0;
      run_len   = '0;
      first_ch  = '0;
      offset    = '0;
    endfunction

    function void push_token(kind_t k, logic [7:0] ch, logic [VALUE_W-1:0] v,
                             logic [POS_W-1:0] s, logic [POS_W-1:0] len, logic lst);
      token_t t;
      t.kind   = k;
      t.ch     = ch;
      t.value  = v;
      t.start  = s;
      t.length = len;
      t.last   = lst;
      token_q.push_back(t);
    endfunction

    // Work out the tokens caused by one accepted character
    function void note_char(logic [7:0] c);
      bit          letter;
      bit          digit;
      bit          blank;
      bit          punct;
      logic [63:0] v;
      letter = (c >= CH_LOWA) && (c <= CH_LOWZ);
      digit  = (c >= CH_DIG0) && (c <= CH_DIG9);
      blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      punct  = 1'b0;
      foreach (PUNCT_SET[i]) if (c == PUNCT_SET[i]) punct = 1'b1;
      chars_taken++;
      if (c == CH_NUL) strings++;

      // rest of a string after an error is dropped
      if (mode == MODE_DISCARD) begin
        if (c == CH_NUL) restart();
        else offset++;
        return;
      end

      // runs keep growing without output
      if (mode == MODE_IDENT && letter) begin
        if (run_len != '1) run_len++;
        offset++;
        return;
      end
      if (mode == MODE_NUMBER && digit) begin
        v   = 64'(acc) * 64'd10 + 64'(c - CH_DIG0);
        acc = (v > 64'(VALUE_MAX)) ? VALUE_MAX : v[VALUE_W-1:0];
        if (run_len != '1) run_len++;
        offset++;
        return;
      end

      // anything else closes a pending run first
      if (mode == MODE_IDENT) push_token(KIND_IDENT, first_ch, '0, run_start, run_len, 1'b0);
      else if (mode == MODE_NUMBER) push_token(KIND_NUMBER, '0, acc, run_start, run_len, 1'b0);
      mode = MODE_IDLE;

      if (c == CH_NUL) begin
        push_token(KIND_END, '0, '0, offset, '0, 1'b1);
        restart();
        return;
      end
      if (blank) begin
        // skipped
      end else if (punct) begin
        push_token(KIND_PUNCT, c, '0, offset, 16'd1, 1'b0);
      end else if (letter) begin
        mode      = MODE_IDENT;
        first_ch  = c;
        run_start = offset;
        run_len   = 16'd1;
        acc       = '0;
      end else if (digit) begin
        mode      = MODE_NUMBER;
        first_ch  = '0;
        run_start = offset;
        run_len   = 16'd1;
        acc       = VALUE_W'(c - CH_DIG0);
      end else begin
        push_token(KIND_ERROR, c, '0, offset, 16'd1, 1'b1);
        mode = MODE_DISCARD;
      end
      offset++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= ERR_SHOWN)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one token transfer with the oldest expectation
    function void check_token(logic [KIND_W-1:0] kind, logic [TDATA_W-1:0] data, logic lst);
      token_t want;
      if (kind < 5) kind_seen[kind]++;
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= ERR_SHOWN)
          $display("%0t: token with none expected: expected nothing, actual kind %0d data %0h",
                   $time, kind, data);
        return;
      end
      want = token_q.pop_front();
      compare_field("token_kind", 64'(want.kind), 64'(kind));
      compare_field("token_char", 64'(want.ch), 64'(data[7:0]));
      compare_field("number_value", 64'(want.value), 64'(data[38:8]));
      compare_field("start_offset", 64'(want.start), 64'(data[54:39]));
      compare_field("token_length", 64'(want.length), 64'(data[70:55]));
      compare_field("last_token", 64'(want.last), 64'(lst));
    endfunction

    function int pending();
      return token_q.size();
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]  m_axis_tuser;
  logic               m_axis_tlast;

  token_scoreboard sb = new();
  bit              no_idle  = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     cycle_count = 0;

  expression_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, sb.pending());
      $display("expression_tokenizer regression: fail");
      $finish;
    end
  end

  // Token monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Receiver: bursts with varying stall rates, plus the requested hold-off
  initial begin
    int burst;
    int pct;
    int held;
    while (rst) @(posedge clk);
    forever begin
      burst = $urandom_range(8, 64);
      case ($urandom_range(3))
        0, 1:    pct = 0;
        2:       pct = 30;
        default: pct = 60;
      endcase
      repeat (burst) begin
        if (hold_req) begin
          hold_req = 1'b0;
          m_axis_tready <= 1'b0;
          held = 0;
          while (held < HOLD_CYCLES) begin
            @(posedge clk);
            held++;
          end
        end else if ($urandom_range(99) < pct) begin
          m_axis_tready <= 1'b0;
          repeat (pick_stall()) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One character transfer, valid kept high across back-to-back transfers
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // One lexical element of a well-formed expression
  task automatic send_part();
    int len;
    int r;
    case ($urandom_range(3))
      0: begin
        len = $urandom_range(1, 8);
        repeat (len) send_char(CH_LOWA + 8'($urandom_range(0, 25)));
      end
      1: begin
        len = ($urandom_range(99) < 12) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (len) send_char(CH_DIG0 + 8'($urandom_range(0, 9)));
      end
      2: send_char(PUNCT_SET[$urandom_range(7)]);
      default: begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          r = $urandom_range(5);
          send_char((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
        end
      end
    endcase
  endtask

  // A random string: mostly well-formed, sometimes with stray bytes or pure noise
  task automatic send_expression();
    int parts;
    int len;
    if ($urandom_range(99) < 6) begin
      len = $urandom_range(1, 8);
      repeat (len) send_char(8'($urandom_range(0, 255)));
      send_char(CH_NUL);
      return;
    end
    parts = $urandom_range(1, 10);
    repeat (parts) begin
      if ($urandom_range(99) < 4) send_char(8'($urandom_range(1, 255)));
      send_part();
    end
    send_char(CH_NUL);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: whitespace ends, every punctuation mark, letter and digit
    // extremes, run flushed by another run, error after an identifier, the
    // discarded tail of a bad string and an empty string
    send_text("\t\r +-*/();= abz 09x7");
    send_char(CH_NUL);
    send_text("q");
    send_char(8'hFF);
    send_text("z");
    send_char(CH_NUL);
    send_char(CH_NUL);

    // Back-pressure: receiver holds off while punctuation keeps coming
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (30) send_char(PUNCT_SET[$urandom_range(7)]);
    send_char(CH_NUL);
    no_idle = 1'b0;

    // Random expressions
    target = sb.chars_taken + RANDOM_ITEMS;
    while (sb.chars_taken < target) send_expression();

    // Closing string: number saturates
    no_idle = 1'b1;
    send_char(CH_PLUS);
    send_text("4294967296");
    send_char(CH_NUL);
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run took %0d characters in %0d strings, with one long receiver hold-off",
             sb.chars_taken, sb.strings);
    $display("Tokens: %0d punctuation, %0d number, %0d identifier, %0d end, %0d error",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("expression_tokenizer regression: pass");
    end else begin
      $display("expression_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
